/* rtl/pwup_pkg.sv */
package pwup_pkg;

  localparam int PAGE_ENTRIES       = 256;
  localparam int WORDS_PER_PAGE_MAX = 1024;
  localparam int COUNT_BITS         = 32;

  localparam int WORD_BYTES_LOG2 = 2;
  localparam int SHIFT_MIN       = 2;
  localparam int SHIFT_MAX       = 12;
  localparam int ROW_BITS        = 64;
  localparam int BIT_W           = 6;
  localparam int ROW_WORDS       = (WORDS_PER_PAGE_MAX + ROW_BITS - 1) / ROW_BITS;

  localparam int PAGE_W = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
  localparam int COL_W  = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int ROW_ADDR_W   = PAGE_W + COL_W;
  localparam int BITMAP_DEPTH = PAGE_ENTRIES * (2 ** COL_W);
  localparam int WORD_FULL_W  = SHIFT_MAX - WORD_BYTES_LOG2;

  localparam int SHIFT_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 1'd1;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = SHIFT_W'(SHIFT_MAX);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [PAGE_W-1:0]     page_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [BIT_W-1:0]      bit_idx_t;

  typedef struct packed {
    logic        command;
    logic [31:0] address;
  } in_word_t;

  typedef struct packed {
    logic        out_of_range;
    logic [31:0] pages_seen;
    logic [31:0] words_used;
    logic [31:0] access_total;
    logic [31:0] max_page_count;
    logic [31:0] page_count;
  } out_word_t;

  // per-page record: a row of the bitmap counts only while its row_valid bit is set
  typedef struct packed {
    logic                 seen;
    count_t               count;
    logic [ROW_WORDS-1:0] row_valid;
  } meta_t;

  typedef struct packed {
    logic  en;
    page_t page;
    col_t  col;
  } store_rd_t;

  typedef struct packed {
    logic  en;
    page_t page;
    col_t  col;
    meta_t meta;
    row_t  row;
  } store_wr_t;

  typedef struct packed {
    meta_t meta;
    row_t  row;
  } store_rd_data_t;

  function automatic count_t sat_inc(count_t v);
    return (&v) ? v : v + count_t'(1);
  endfunction

  function automatic logic [31:0] to_out32(count_t v);
    logic [63:0] w;
    w = 64'(v);
    return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

/* rtl/pwup_store.sv */
module pwup_store (
  input  logic                     clk,
  input  logic                     rst,
  input  pwup_pkg::store_rd_t      rd,
  input  pwup_pkg::store_wr_t      wr,
  output pwup_pkg::store_rd_data_t rd_data
);
  import pwup_pkg::*;

  meta_t meta_mem [PAGE_ENTRIES];
  row_t  bitmap_mem [BITMAP_DEPTH];

  logic [PAGE_ENTRIES-1:0] page_valid;

  meta_t meta_q;
  row_t  row_q;
  logic  valid_q;
  col_t  col_q;

  // page records and bitmap rows, registered read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      meta_q  <= meta_mem[rd.page];
      row_q   <= bitmap_mem[{rd.page, rd.col}];
      valid_q <= page_valid[rd.page];
      col_q   <= rd.col;
    end
    if (wr.en) begin
      meta_mem[wr.page]             <= wr.meta;
      bitmap_mem[{wr.page, wr.col}] <= wr.row;
    end
  end

  // a page never written since reset reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid <= '0;
    end else if (wr.en) begin
      page_valid[wr.page] <= 1'b1;
    end
  end

  always_comb begin
    rd_data.meta = valid_q ? meta_q : '0;
    rd_data.row  = (valid_q && meta_q.row_valid[col_q]) ? row_q : '0;
  end

endmodule

/* rtl/page_word_usage_profiler.sv */
// page word usage profiler
//
// item channel (item_valid / item_ready / item): one word per memory access,
// a byte address and a command bit that evicts the page before the access.
// result channel (result_valid / result_ready / result): exactly one word per
// item, with the running totals after that access and the page's count.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// enable, index 1 is page_shift; always ready, write only while idle.
//
// the item and its read data are registered at accept, and the result register
// is loaded at write back; no new item is taken until the read-modify-write of
// the per-page record and bitmap row (read at accept) is written back.
// a stalled receiver holds the result register; one more item is still
// accepted and waits, read data held, until the result register frees up.
// reset clears the totals, the config (disabled, page_shift 12) and the page
// valid flags, so every page reads as empty at once; no clearing pass.
module page_word_usage_profiler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  pwup_pkg::in_word_t                  item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output pwup_pkg::out_word_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwup_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwup_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pwup_pkg::*;

  // configuration registers
  logic               enable;
  logic [SHIFT_W-1:0] page_shift;

  // running totals
  count_t pages_seen_total;
  count_t words_used_total;
  count_t accesses_total;
  count_t max_count;

  // item held between accept and write back
  logic     busy;
  logic     cmd_q;
  logic     act_q;
  logic     oor_q;
  page_t    page_q;
  col_t     col_q;
  bit_idx_t bit_q;

  logic accept;
  logic commit;

  store_rd_t      rd;
  store_wr_t      wr;
  store_rd_data_t rd_data;

  assign cfg_ready  = 1'b1;
  assign item_ready = !busy;
  assign accept     = item_valid && item_ready;
  // write back only once the result register is free or being emptied
  assign commit     = busy && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      page_shift <= PAGE_SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLE:     enable     <= cfg_data[0];
        CFG_PAGE_SHIFT: page_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // address split: clamp the shift, page above it, word index below it
  logic [SHIFT_W-1:0]     sh;
  logic [31:0]            page_full;
  logic [SHIFT_MAX:0]     offs_mask;
  logic [SHIFT_MAX-1:0]   offs;
  logic [WORD_FULL_W-1:0] word_full;
  logic [15:0]            word_ext;
  logic                   in_oor;

  always_comb begin
    if (page_shift < SHIFT_W'(SHIFT_MIN)) begin
      sh = SHIFT_W'(SHIFT_MIN);
    end else if (page_shift > SHIFT_W'(SHIFT_MAX)) begin
      sh = SHIFT_W'(SHIFT_MAX);
    end else begin
      sh = page_shift;
    end
    page_full = item.address >> sh;
    offs_mask = ((SHIFT_MAX + 1)'(1) << sh) - (SHIFT_MAX + 1)'(1);
    offs      = item.address[SHIFT_MAX-1:0] & offs_mask[SHIFT_MAX-1:0];
    word_full = offs[SHIFT_MAX-1:WORD_BYTES_LOG2];
    word_ext  = 16'(word_full);
    in_oor    = (page_full >= 32'(PAGE_ENTRIES)) ||
                (32'(word_full) >= 32'(WORDS_PER_PAGE_MAX));
  end

  assign rd.en   = accept;
  assign rd.page = page_full[PAGE_W-1:0];
  assign rd.col  = word_ext[COL_W+BIT_W-1:BIT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (commit) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= item.command;
      act_q  <= enable && !in_oor;
      oor_q  <= enable && in_oor;
      page_q <= rd.page;
      col_q  <= rd.col;
      bit_q  <= word_ext[BIT_W-1:0];
    end
  end

  // read-modify-write of the page record and bitmap row
  meta_t  meta_in;
  row_t   row_in;
  row_t   bit_mask;
  logic   new_word;
  logic   new_page;
  count_t cnt_new;
  count_t pages_next;
  count_t words_next;
  count_t accesses_next;
  count_t max_next;

  always_comb begin
    // eviction empties the page before the access lands on it
    meta_in  = cmd_q ? '0 : rd_data.meta;
    row_in   = cmd_q ? '0 : rd_data.row;
    bit_mask = row_t'(1) << bit_q;
    new_word = (row_in & bit_mask) == '0;
    new_page = !meta_in.seen;
    cnt_new  = sat_inc(meta_in.count);

    pages_next    = pages_seen_total;
    words_next    = words_used_total;
    accesses_next = accesses_total;
    max_next      = max_count;
    if (act_q) begin
      if (new_page) begin
        pages_next = sat_inc(pages_seen_total);
      end
      if (new_word) begin
        words_next = sat_inc(words_used_total);
      end
      accesses_next = sat_inc(accesses_total);
      if (cnt_new > max_count) begin
        max_next = cnt_new;
      end
    end

    wr.en                  = commit && act_q;
    wr.page                = page_q;
    wr.col                 = col_q;
    wr.meta.seen           = 1'b1;
    wr.meta.count          = cnt_new;
    wr.meta.row_valid      = meta_in.row_valid;
    wr.meta.row_valid[col_q] = 1'b1;
    wr.row                 = row_in | bit_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_seen_total <= '0;
      words_used_total <= '0;
      accesses_total   <= '0;
      max_count        <= '0;
    end else if (commit) begin
      pages_seen_total <= pages_next;
      words_used_total <= words_next;
      accesses_total   <= accesses_next;
      max_count        <= max_next;
    end
  end

  pwup_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .wr      (wr),
    .rd_data (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.out_of_range   <= oor_q;
      result.pages_seen     <= to_out32(pages_next);
      result.words_used     <= to_out32(words_next);
      result.access_total   <= to_out32(accesses_next);
      result.max_page_count <= to_out32(max_next);
      result.page_count     <= act_q ? to_out32(cnt_new) : 32'd0;
    end
  end

  // a new result only ever comes out of a pending write back
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(busy))
    else $error("result appeared without a pending item");

  // totals are never lowered outside reset
  a_totals_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (accesses_total >= $past(accesses_total)) &&
                    (words_used_total >= $past(words_used_total)) &&
                    (pages_seen_total >= $past(pages_seen_total)))
    else $error("running total decreased");

  a_max_covers_page: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.max_page_count >= result.page_count)
    else $error("page count above the maximum");

  a_oor_no_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_of_range |-> result.page_count == 32'd0)
    else $error("ignored access reported a page count");

endmodule

/* sim/tb.sv */
module tb;
  import pwup_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 208;
  localparam int SETTLE_CYCLES = 4;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_EVICT  = 1'b1;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  in_word_t              item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  out_word_t             result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  page_word_usage_profiler dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // profile state as the block should hold it
  logic [WORDS_PER_PAGE_MAX-1:0] touched_words [PAGE_ENTRIES];
  logic                          page_touched  [PAGE_ENTRIES];
  count_t                        page_hits     [PAGE_ENTRIES];
  count_t                        pages_seen_sum;
  count_t                        words_used_sum;
  count_t                        access_sum;
  count_t                        peak_hits;
  logic                          prof_enable;
  logic [SHIFT_W-1:0]            prof_shift;

  out_word_t expected_results [$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic count_t bump_count(count_t v);
    return (&v) ? v : v + count_t'(1);
  endfunction

  // page_shift outside 2..12 is clamped
  function automatic int unsigned effective_shift();
    if (prof_shift < SHIFT_MIN) return SHIFT_MIN;
    if (prof_shift > SHIFT_MAX) return SHIFT_MAX;
    return 32'(prof_shift);
  endfunction

  function automatic void clear_profile();
    for (int p = 0; p < PAGE_ENTRIES; p++) begin
      touched_words[p] = '0;
      page_touched[p]  = 1'b0;
      page_hits[p]     = '0;
    end
    pages_seen_sum = '0;
    words_used_sum = '0;
    access_sum     = '0;
    peak_hits      = '0;
    prof_enable    = 1'b0;
    prof_shift     = PAGE_SHIFT_RESET;
  endfunction

  // updates the profile for one access and returns the word the block should report
  function automatic out_word_t profile_access(in_word_t w);
    out_word_t   r;
    int unsigned sh;
    logic [31:0] pg;
    logic [31:0] wd;
    r = '0;
    if (prof_enable) begin
      sh = effective_shift();
      pg = w.address >> sh;
      wd = (w.address & ((32'd1 << sh) - 32'd1)) >> WORD_BYTES_LOG2;
      if (pg >= PAGE_ENTRIES || wd >= WORDS_PER_PAGE_MAX) begin
        // ignored, eviction included
        r.out_of_range = 1'b1;
      end else begin
        if (w.command == CMD_EVICT) begin
          touched_words[pg] = '0;
          page_touched[pg]  = 1'b0;
          page_hits[pg]     = '0;
        end
        if (!touched_words[pg][wd]) begin
          touched_words[pg][wd] = 1'b1;
          words_used_sum = bump_count(words_used_sum);
        end
        if (!page_touched[pg]) begin
          page_touched[pg] = 1'b1;
          pages_seen_sum = bump_count(pages_seen_sum);
        end
        page_hits[pg] = bump_count(page_hits[pg]);
        access_sum    = bump_count(access_sum);
        if (page_hits[pg] > peak_hits) peak_hits = page_hits[pg];
        r.page_count = 32'(page_hits[pg]);
      end
    end
    r.pages_seen     = 32'(pages_seen_sum);
    r.words_used     = 32'(words_used_sum);
    r.access_total   = 32'(access_sum);
    r.max_page_count = 32'(peak_hits);
    return r;
  endfunction

  // mostly hot pages so counts and word hits repeat, some sparse and out-of-table
  function automatic logic [31:0] random_address();
    int unsigned sh;
    int unsigned roll;
    int unsigned pg;
    logic [31:0] a;
    sh   = effective_shift();
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      pg = (roll < 55) ? $urandom_range(0, 7) : $urandom_range(0, PAGE_ENTRIES - 1);
      a  = (32'(pg) << sh) | ($urandom & ((32'd1 << sh) - 32'd1));
    end else begin
      a = $urandom;
      if (roll < 90 && (a >> sh) < PAGE_ENTRIES) a[31] = 1'b1;
    end
    return a;
  endfunction

  // one access word; valid is held until accepted
  task automatic send_access(input logic cmd, input logic [31:0] addr);
    in_word_t w;
    w.command = cmd;
    w.address = addr;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (!item_ready);
    expected_results.push_back(profile_access(w));
  endtask

  // stop sending, wait for every result, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLE:     prof_enable = data[0];
      CFG_PAGE_SHIFT: prof_shift  = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits of the enable write are junk and must be ignored
  task automatic apply_setting(input logic en, input logic [SHIFT_W-1:0] sh);
    drain_results();
    write_register(CFG_PAGE_SHIFT, sh);
    write_register(CFG_ENABLE, {3'($urandom), en});
  endtask

  // after reset the block is disabled: nothing counts, page_count reads zero
  task automatic test_disabled_after_reset();
    send_access(CMD_ACCESS, 32'h0000_0000);
    send_access(CMD_EVICT, 32'hFFFF_FFFF);
  endtask

  // reset page_shift of 12 left in place, only enable written
  task automatic test_access_basics();
    drain_results();
    write_register(CFG_ENABLE, 4'h1);
    send_access(CMD_ACCESS, 32'h0000_0000);   // new page, new word
    send_access(CMD_ACCESS, 32'h0000_0000);   // repeat hit
    send_access(CMD_ACCESS, 32'h0000_0003);   // same word, other byte
    send_access(CMD_ACCESS, 32'h0000_0004);   // next word
    send_access(CMD_ACCESS, 32'h0000_0FFC);   // last word of the page
    send_access(CMD_ACCESS, 32'h000F_FFFF);   // last page, last word
    send_access(CMD_ACCESS, 32'h0010_0000);   // first page past the table
    send_access(CMD_EVICT,  32'hFFFF_FFFF);   // eviction past the table is ignored
    send_access(CMD_EVICT,  32'h0000_0000);   // evict a busy page, pages and words count anew
    send_access(CMD_EVICT,  32'h0000_5000);   // evict a page never touched
    send_access(CMD_ACCESS, 32'h7FFF_FFFF);
    send_access(CMD_ACCESS, 32'h8000_0000);
  endtask

  // smallest and largest page sizes, and shift values clamped from both sides
  task automatic test_shift_limits();
    apply_setting(1'b1, 4'd2);
    send_access(CMD_ACCESS, 32'h0000_0000);
    send_access(CMD_ACCESS, 32'h0000_03FC);   // page 255
    send_access(CMD_ACCESS, 32'h0000_0400);   // page 256
    apply_setting(1'b1, 4'd0);
    send_access(CMD_ACCESS, 32'h0000_03FF);
    send_access(CMD_EVICT,  32'h0000_0001);
    apply_setting(1'b1, 4'd1);
    send_access(CMD_ACCESS, 32'h0000_0002);
    apply_setting(1'b1, 4'd15);
    send_access(CMD_ACCESS, 32'h000F_FFFF);
    send_access(CMD_ACCESS, 32'h0010_0000);
    apply_setting(1'b1, 4'd13);
    send_access(CMD_ACCESS, 32'h0000_1FFC);
  endtask

  // random accesses across page sizes and idling patterns; the profile carries over
  task automatic test_random_profile();
    logic               en_plan    [9] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                                           1'b1};
    logic [SHIFT_W-1:0] shift_plan [9] = '{4'd12, 4'd2, 4'd7, 4'd0, 4'd15, 4'd5, 4'd2,
                                           4'd12, 4'd9};
    for (int ph = 0; ph < 9; ph++) begin
      apply_setting(en_plan[ph], shift_plan[ph]);
      case (ph / 3)
        0: begin send_idle_pct = 22; recv_stall_pct = 55; end
        1: begin send_idle_pct = 55; recv_stall_pct = 22; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_access(($urandom_range(0, 9) == 0) ? CMD_EVICT : CMD_ACCESS, random_address());
      end
    end
  endtask

  always @(negedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (result.out_of_range !== want.out_of_range) begin
          $error("out_of_range exp %0h got %0h", want.out_of_range, result.out_of_range);
          mismatches++;
        end
        if (result.pages_seen !== want.pages_seen) begin
          $error("pages_seen exp %0h got %0h", want.pages_seen, result.pages_seen);
          mismatches++;
        end
        if (result.words_used !== want.words_used) begin
          $error("words_used exp %0h got %0h", want.words_used, result.words_used);
          mismatches++;
        end
        if (result.access_total !== want.access_total) begin
          $error("access_total exp %0h got %0h", want.access_total, result.access_total);
          mismatches++;
        end
        if (result.max_page_count !== want.max_page_count) begin
          $error("max_page_count exp %0h got %0h", want.max_page_count,
                 result.max_page_count);
          mismatches++;
        end
        if (result.page_count !== want.page_count) begin
          $error("page_count exp %0h got %0h", want.page_count, result.page_count);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    clear_profile();
    send_idle_pct  = 22;
    recv_stall_pct = 55;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    test_disabled_after_reset();
    test_access_basics();
    test_shift_limits();
    test_random_profile();
    drain_results();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
